// File: rtl/dbse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbse_pkg
// Shared types and constants of the DLE byte-stuffing escaper.
// ----------------------------------------------------------------------------
package dbse_pkg;

	localparam int BUF_BYTES_DEF = 128;
	localparam int MASK_W        = 32;
	localparam int BYTE_W        = 8;
	localparam int COUNT_W       = 8;

	localparam logic [BYTE_W-1:0] DLE_CODE = 8'h10;

	typedef enum logic {
		OP_DATA  = 1'b0,
		OP_FLUSH = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [BYTE_W-1:0]   data_byte;
		logic                end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic                out_valid;
		logic                run_last;
		logic                rejected;
		logic [COUNT_W-1:0]  accepted_count;
	} out_item_t;

	// one or two results produced by a single input transaction
	typedef struct packed {
		logic      two;
		out_item_t first;
		out_item_t second;
	} res_pair_t;

endpackage

// File: rtl/dbse_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbse_in_stage
// Input register: holds one accepted item until the core takes it.
// ----------------------------------------------------------------------------
module dbse_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dbse_pkg::in_item_t in_item,
	input  logic              take,
	output logic              valid_s1,
	output dbse_pkg::in_item_t item_s1
);
	import dbse_pkg::*;

	logic load;

	assign in_stall = valid_s1 && !take;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: rtl/dbse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbse_core
// Escape decision, buffer fill check and string state; produces the results
// of one item in a single pass.
// ----------------------------------------------------------------------------
module dbse_core #(
	parameter int BUF_BYTES = dbse_pkg::BUF_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dbse_pkg::MASK_W-1:0] cfg_wdata,
	input  logic                        take,
	input  dbse_pkg::in_item_t          item_s1,
	output dbse_pkg::res_pair_t         pair
);
	import dbse_pkg::*;

	localparam int FW = $clog2(BUF_BYTES);
	localparam logic [FW:0] LIMIT = (FW+1)'(BUF_BYTES - 1);

	logic [MASK_W-1:0]  style_mask_q;
	logic [FW-1:0]      fill_q;
	logic               stopped_q;
	logic [COUNT_W-1:0] count_q;

	logic [BYTE_W-1:0]  folded;
	logic               esc;
	logic [FW:0]        need;
	logic               over;
	logic               reject;
	logic [COUNT_W-1:0] count_inc;
	logic               is_flush;

	// DEL and 0xff fold onto BS and NUL before the mask lookup
	always_comb begin
		unique case (item_s1.data_byte)
			8'h7f:   folded = 8'h08;
			8'hff:   folded = 8'h00;
			default: folded = item_s1.data_byte;
		endcase
	end

	assign esc       = (folded < 8'h20) && style_mask_q[folded[4:0]];
	assign need      = esc ? (FW+1)'(2) : (FW+1)'(1);
	assign over      = ({1'b0, fill_q} + need) >= LIMIT;
	assign reject    = stopped_q || over;
	assign count_inc = (count_q == '1) ? count_q : count_q + COUNT_W'(1);
	assign is_flush  = (item_s1.opcode == OP_FLUSH);

	always_comb begin
		pair.two                   = 1'b0;
		pair.first.out_byte        = '0;
		pair.first.out_valid       = 1'b0;
		pair.first.run_last        = 1'b1;
		pair.first.rejected        = 1'b0;
		pair.first.accepted_count  = count_q;
		if (!is_flush) begin
			if (reject) begin
				pair.first.rejected = 1'b1;
			end else begin
				pair.first.accepted_count = count_inc;
				pair.first.out_valid      = 1'b1;
				if (esc) begin
					pair.two               = 1'b1;
					pair.first.out_byte    = DLE_CODE;
					pair.first.run_last    = 1'b0;
				end else begin
					pair.first.out_byte    = item_s1.data_byte;
				end
			end
		end
		pair.second                = pair.first;
		pair.second.out_byte       = item_s1.data_byte ^ 8'h40;
		pair.second.run_last       = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			style_mask_q <= '0;
		end else if (cfg_we) begin
			style_mask_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			stopped_q <= 1'b0;
			count_q   <= '0;
		end else if (take) begin
			if (is_flush) begin
				fill_q <= '0;
			end else begin
				if (!reject) begin
					fill_q <= fill_q + need[FW-1:0];
				end
				// end of string wins over the string updates
				priority if (item_s1.end_of_string) begin
					stopped_q <= 1'b0;
					count_q   <= '0;
				end else if (reject) begin
					stopped_q <= 1'b1;
				end else begin
					count_q <= count_inc;
				end
			end
		end
	end

endmodule

// File: rtl/dbse_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbse_out_queue
// Two-slot result register: loads a result pair and hands the results out
// one per transaction.
// ----------------------------------------------------------------------------
module dbse_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  dbse_pkg::res_pair_t pair,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output dbse_pkg::out_item_t out_item
);
	import dbse_pkg::*;

	logic [1:0] cnt_q;
	out_item_t  slot0_q;
	out_item_t  slot1_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = slot0_q;
	assign pop       = out_valid && !out_stall;
	// a new pair only goes in once the queue is, or is about to be, empty
	assign room      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= pair.two ? 2'd2 : 2'd1;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= pair.first;
			slot1_q <= pair.second;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

// File: rtl/dle_byte_stuffing_escaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_byte_stuffing_escaper
// DLE byte stuffing of a string stream into a bounded output buffer.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_item): data bytes, end-of-string
// marks and flush commands; a transaction completes when in_valid is high
// and in_stall low. Output channel (out_valid / out_stall / out_item): one
// result per transaction, an escaped byte gives a DLE result followed by
// the payload result, everything else gives exactly one result.
// An item passes the input register, then the result register, before its
// first result is on out_item. Throughput: one item per cycle for plain,
// rejected and flush items while the receiver does not stall; an escaped
// byte gives two results, and the next item is taken only as the second
// of them leaves the result register. The user must write style_mask
// through cfg_we / cfg_wdata only while the block is idle; the block
// itself does not enforce this. Reset clears the mask, the fill level,
// the string count and the stop flag and empties both registers. When the
// receiver stalls, the result holds, the input register fills and in_stall
// then rises until room returns.
// ----------------------------------------------------------------------------
module dle_byte_stuffing_escaper #(
	parameter int BUF_BYTES = dbse_pkg::BUF_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dbse_pkg::MASK_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  dbse_pkg::in_item_t          in_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output dbse_pkg::out_item_t         out_item
);
	import dbse_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      room;
	logic      take;
	res_pair_t pair;

	assign take = valid_s1 && room;

	dbse_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	dbse_core #(
		.BUF_BYTES (BUF_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.item_s1   (item_s1),
		.pair      (pair)
	);

	dbse_out_queue u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.pair      (pair),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// File: rtl/dbse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbse_port_checker
// Port-level checks of the escaper, bound to the top level.
// ----------------------------------------------------------------------------
module dbse_port_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input dbse_pkg::out_item_t out_item
);
	import dbse_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// a non-final result is always the DLE prefix of a written byte
	a_prefix_is_dle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.run_last |->
			out_item.out_valid && out_item.out_byte == DLE_CODE)
		else $error("non-final result is not a DLE prefix");

	// the payload follows its prefix straight away
	a_payload_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_item.run_last |=> out_valid)
		else $error("payload missing after DLE prefix");

	// a rejected byte is never written
	a_reject_unwritten: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.rejected |->
			out_item.run_last && !out_item.out_valid && out_item.out_byte == '0)
		else $error("rejected result carries a written byte");

endmodule

bind dle_byte_stuffing_escaper dbse_port_checker u_dbse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// File: test/dbse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbse_checker
// Watches both channels and the mask register port of the escaper. It keeps
// its own copy of the mask, fill level and string state, works out the
// result bytes for every input transaction and compares each output
// transaction, field by field, with the oldest result still outstanding.
// ----------------------------------------------------------------------------
module dbse_checker #(
	parameter int BUF_BYTES = dbse_pkg::BUF_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dbse_pkg::MASK_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  dbse_pkg::in_item_t          in_item,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  dbse_pkg::out_item_t         out_item,
	output int                          mismatches,
	output int                          awaiting,
	output int                          results_seen,
	output int                          escapes_seen,
	output int                          rejects_seen,
	output int                          peak_count
);
	import dbse_pkg::*;

	logic [MASK_W-1:0]  style_mask;
	int                 fill_level;
	logic               string_stopped;
	logic [COUNT_W-1:0] string_count;
	out_item_t          stuffed_q[$];

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("%0t dbse_checker: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
	endtask

	function automatic logic needs_escape(logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] folded;
		folded = b;
		if (b == 8'h7f) begin
			folded = 8'h08;
		end else if (b == 8'hff) begin
			folded = 8'h00;
		end
		if (folded >= 8'h20) begin
			return 1'b0;
		end
		return style_mask[folded[4:0]];
	endfunction

	function automatic out_item_t make_result(logic [BYTE_W-1:0] b, logic v, logic last,
			logic rej);
		out_item_t r;
		r.out_byte       = b;
		r.out_valid      = v;
		r.run_last       = last;
		r.rejected       = rej;
		r.accepted_count = string_count;
		return r;
	endfunction

	task automatic stuff_byte(in_item_t it);
		logic esc;
		int   need;
		if (it.opcode == OP_FLUSH) begin
			// string state survives a flush, only the buffer empties
			fill_level = 0;
			stuffed_q.push_back(make_result('0, 1'b0, 1'b1, 1'b0));
			return;
		end
		esc  = needs_escape(it.data_byte);
		need = esc ? 2 : 1;
		if (string_stopped || (fill_level + need >= BUF_BYTES - 1)) begin
			string_stopped = 1'b1;
			rejects_seen++;
			stuffed_q.push_back(make_result('0, 1'b0, 1'b1, 1'b1));
		end else begin
			if (string_count != '1) begin
				string_count++;
			end
			if (string_count > peak_count) begin
				peak_count = string_count;
			end
			if (esc) begin
				escapes_seen++;
				stuffed_q.push_back(make_result(DLE_CODE, 1'b1, 1'b0, 1'b0));
				stuffed_q.push_back(make_result(it.data_byte ^ 8'h40, 1'b1, 1'b1, 1'b0));
			end else begin
				stuffed_q.push_back(make_result(it.data_byte, 1'b1, 1'b1, 1'b0));
			end
			fill_level += need;
		end
		// count is reported before the end-of-string clear
		if (it.end_of_string) begin
			string_stopped = 1'b0;
			string_count   = '0;
		end
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		results_seen++;
		if (stuffed_q.size() == 0) begin
			report_mismatch("result with nothing outstanding, out_byte", got.out_byte, 0);
			return;
		end
		want = stuffed_q.pop_front();
		if (got.out_byte !== want.out_byte) begin
			report_mismatch("out_byte", got.out_byte, want.out_byte);
		end
		if (got.out_valid !== want.out_valid) begin
			report_mismatch("out_valid", got.out_valid, want.out_valid);
		end
		if (got.run_last !== want.run_last) begin
			report_mismatch("run_last", got.run_last, want.run_last);
		end
		if (got.rejected !== want.rejected) begin
			report_mismatch("rejected", got.rejected, want.rejected);
		end
		if (got.accepted_count !== want.accepted_count) begin
			report_mismatch("accepted_count", got.accepted_count, want.accepted_count);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			style_mask     = '0;
			fill_level     = 0;
			string_stopped = 1'b0;
			string_count   = '0;
			stuffed_q.delete();
			mismatches     = 0;
			awaiting       = 0;
			results_seen   = 0;
			escapes_seen   = 0;
			rejects_seen   = 0;
			peak_count     = 0;
		end else begin
			if (cfg_we) begin
				style_mask = cfg_wdata;
			end
			if (out_valid && !out_stall) begin
				check_result(out_item);
			end
			if (in_valid && !in_stall) begin
				stuff_byte(in_item);
			end
			awaiting = stuffed_q.size();
		end
	end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the DLE byte-stuffing escaper. A short directed
// run over the folding and escape boundaries is followed by random strings
// under several style masks and idle patterns, a string long enough to
// saturate the byte count, and long receiver hold-offs that back the block
// up. Checking is done by the dbse_checker instance beside the block.
// ----------------------------------------------------------------------------
module tb_top;
	import dbse_pkg::*;

	typedef enum int {
		IDLE_NONE,
		IDLE_SRC,
		IDLE_SNK,
		IDLE_BOTH
	} idle_mode_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [MASK_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_stall;
	in_item_t          in_item;
	logic              out_valid;
	logic              out_stall;
	out_item_t         out_item;

	int mismatches;
	int awaiting;
	int results_seen;
	int escapes_seen;
	int rejects_seen;
	int peak_count;

	int   items_sent;
	int   src_idle_pct;
	int   snk_stall_pct;
	logic hold_req;
	int   hold_len;

	dle_byte_stuffing_escaper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	dbse_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_item      (in_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_item     (out_item),
		.mismatches   (mismatches),
		.awaiting     (awaiting),
		.results_seen (results_seen),
		.escapes_seen (escapes_seen),
		.rejects_seen (rejects_seen),
		.peak_count   (peak_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_top: errors");
		$finish;
	end

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (hold_len - 1) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < snk_stall_pct);
			end
		end
	end

	function automatic in_item_t data_item(logic [BYTE_W-1:0] b, logic eos);
		in_item_t it;
		it.opcode        = OP_DATA;
		it.data_byte     = b;
		it.end_of_string = eos;
		return it;
	endfunction

	function automatic in_item_t flush_item();
		in_item_t it;
		// byte and end mark are don't-care on a flush, so vary them
		it.opcode        = OP_FLUSH;
		it.data_byte     = BYTE_W'($urandom_range(255));
		it.end_of_string = 1'($urandom_range(1));
		return it;
	endfunction

	// bias towards control codes and the folded values
	function automatic logic [BYTE_W-1:0] pick_byte();
		int r;
		r = $urandom_range(9);
		if (r < 4) begin
			return BYTE_W'($urandom_range(31));
		end else if (r == 4) begin
			return 8'h7f;
		end else if (r == 5) begin
			return 8'hff;
		end else if (r == 6) begin
			return DLE_CODE;
		end
		return BYTE_W'($urandom_range(255));
	endfunction

	task automatic set_mode(idle_mode_t m);
		case (m)
			IDLE_NONE: begin
				src_idle_pct = 0;  snk_stall_pct = 0;
			end
			IDLE_SRC: begin
				src_idle_pct = 54; snk_stall_pct = 0;
			end
			IDLE_SNK: begin
				src_idle_pct = 0;  snk_stall_pct = 54;
			end
			default: begin
				src_idle_pct = 26; snk_stall_pct = 26;
			end
		endcase
	endtask

	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// drop valid and wait until every outstanding result has come back
	task automatic pause_input();
		in_valid <= 1'b0;
		@(negedge clk);
		while (awaiting != 0) @(negedge clk);
	endtask

	task automatic write_style(logic [MASK_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	task automatic hold_receiver(int cycles);
		hold_len = cycles;
		hold_req = 1'b1;
	endtask

	task automatic random_traffic(int n);
		int start = items_sent;
		int k;
		int len;
		logic broken;
		while (items_sent - start < n) begin
			k = $urandom_range(99);
			if (k < 9) begin
				send_item(flush_item());
			end else if (k < 17) begin
				send_item(data_item(BYTE_W'($urandom_range(255)), 1'($urandom_range(1))));
			end else begin
				len    = $urandom_range(1, 20);
				broken = ($urandom_range(9) == 0);
				for (int i = 0; i < len; i++) begin
					send_item(data_item(pick_byte(), (i == len - 1) && !broken));
				end
			end
		end
	endtask

	// one string of 276 data bytes with flushes inside, past the count ceiling
	task automatic long_string();
		for (int i = 0; i < 280; i++) begin
			if (i % 60 == 59) begin
				send_item(flush_item());
			end else begin
				send_item(data_item(BYTE_W'($urandom_range(255)), i == 279));
			end
		end
	endtask

	task automatic directed_run();
		send_item(data_item(8'h00, 1'b0));
		send_item(data_item(8'h1f, 1'b0));
		send_item(data_item(8'h20, 1'b0));
		send_item(data_item(8'h7f, 1'b0));
		send_item(data_item(8'hff, 1'b0));
		send_item(data_item(DLE_CODE, 1'b0));
		send_item(data_item(8'h80, 1'b0));
		send_item(data_item(8'hfe, 1'b0));
		send_item(data_item(8'h40, 1'b0));
		send_item(data_item(8'h41, 1'b1));
		send_item(flush_item());
		send_item(data_item(8'h0a, 1'b0));
		send_item(data_item(8'h5a, 1'b0));
		send_item(flush_item());
		send_item(data_item(8'ha5, 1'b0));
		send_item(data_item(8'h08, 1'b1));
		send_item(data_item(8'h0d, 1'b1));
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		in_valid      = 1'b0;
		in_item       = '0;
		items_sent    = 0;
		hold_req      = 1'b0;
		hold_len      = 0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_style(32'hffff_ffff);
		set_mode(IDLE_NONE);
		directed_run();

		pause_input();
		write_style(32'h0000_0000);
		set_mode(IDLE_SRC);
		random_traffic(110);

		pause_input();
		write_style($urandom);
		set_mode(IDLE_SNK);
		random_traffic(55);
		hold_receiver(150);
		random_traffic(55);

		pause_input();
		write_style($urandom);
		set_mode(IDLE_BOTH);
		long_string();

		pause_input();
		write_style(32'hffff_ffff);
		random_traffic(110);

		pause_input();
		write_style($urandom);
		set_mode(IDLE_NONE);
		random_traffic(40);
		hold_receiver(200);
		random_traffic(70);

		pause_input();
		repeat (8) @(negedge clk);

		$display("summary: %0d input transactions over six mask settings, %0d results",
			items_sent, results_seen);
		$display("summary: %0d escaped bytes, %0d rejected bytes, peak string count %0d",
			escapes_seen, rejects_seen, peak_count);
		if (mismatches == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

// File: dle_byte_stuffing_escaper.f
rtl/dbse_pkg.sv
rtl/dbse_in_stage.sv
rtl/dbse_core.sv
rtl/dbse_out_queue.sv
rtl/dle_byte_stuffing_escaper.sv
rtl/dbse_checker.sv
test/dbse_checker.sv
test/tb_top.sv
